// File: rtl/assert_macros.svh
// Assertion macros used by the RTL back end of the packed array access core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/pbaa_pkg.sv
// Types, constants and helper functions of the packed array access core.
`default_nettype none
package pbaa_pkg;

   localparam int WORD_W  = 64;
   localparam int POS_W   = 18;
   localparam int EBITS_W = 7;
   localparam int OFF_W   = 6;
   // word index of any element start: bit position fits in 24 bits
   localparam int WIDX_W  = 18;

   // operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   // classified item handed from the front to the back
   typedef struct packed {
      logic                 operation;
      logic                 err;
      logic                 spans;
      logic [OFF_W-1:0]     offset;
      logic [EBITS_W-1:0]   width;
      logic [WIDX_W-1:0]    word;
      logic [WORD_W-1:0]    value;
   } work_item_type;

   // queue fill status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // all-ones mask of the low w bits, w in 1..64
   function automatic logic [WORD_W-1:0] width_mask(input logic [EBITS_W-1:0] w);
      logic [WORD_W-1:0] m;
      if (w >= 7'd64) begin
         m = '1;
      end else begin
         m = (64'd1 << w) - 64'd1;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// File: rtl/pbaa_if.sv
// Valid/ready channel interfaces for request and response items.
`default_nettype none
interface pbaa_req_if;
   import pbaa_pkg::*;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [POS_W-1:0]   position;
   logic [WORD_W-1:0]  value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink (input valid, input operation, input position, input value,
                 output ready);
endinterface

interface pbaa_rsp_if;
   import pbaa_pkg::*;
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  read_value;
   logic               out_of_range;

   modport source (output valid, output read_value, output out_of_range, input ready);
   modport sink (input valid, input read_value, input out_of_range, output ready);
endinterface
`default_nettype wire

// File: rtl/pbaa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pbaa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/pbaa_front.sv
// Front end: width register, request acceptance and item classification.
`default_nettype none
module pbaa_front #(
   parameter int STORE_WORDS = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [pbaa_pkg::EBITS_W-1:0]      csr_write_data,
   pbaa_req_if.sink                               req_chan,
   input  wire logic                              clearing,
   input  wire pbaa_pkg::queue_status_type        q_status,
   output logic                                   push,
   output pbaa_pkg::work_item_type                push_item
);
   import pbaa_pkg::*;

   localparam int PROD_W  = 25;
   localparam int LIM_W   = $clog2(STORE_WORDS) + 7;
   localparam int CMP_W   = (LIM_W > PROD_W) ? LIM_W : PROD_W;
   localparam logic [CMP_W-1:0] STORE_BITS = CMP_W'(STORE_WORDS) << 6;

   logic [EBITS_W-1:0] element_bits_ff;
   logic [EBITS_W-1:0] element_bits_in;
   logic [EBITS_W-1:0] w_eff;
   logic [PROD_W-1:0]  bitpos;
   logic [PROD_W-1:0]  last_bit;
   logic [EBITS_W-1:0] end_in_word;

   // hold the element width register
   always_comb begin
      element_bits_in = element_bits_ff;
      if (csr_write_enable) begin
         element_bits_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         element_bits_ff <= 7'd1;
      end else begin
         element_bits_ff <= element_bits_in;
      end
   end

   // saturate the width into 1..64
   always_comb begin
      if (element_bits_ff == 7'd0) begin
         w_eff = 7'd1;
      end else if (element_bits_ff > 7'd64) begin
         w_eff = 7'd64;
      end else begin
         w_eff = element_bits_ff;
      end
   end

   // locate the element and check it against the store end
   assign bitpos      = {7'd0, req_chan.position} * {18'd0, w_eff};
   assign last_bit    = bitpos + PROD_W'(w_eff);
   assign end_in_word = EBITS_W'(bitpos[OFF_W-1:0]) + w_eff;

   always_comb begin
      push_item.operation = req_chan.operation;
      push_item.err       = CMP_W'(last_bit) > STORE_BITS;
      push_item.spans     = end_in_word > 7'd64;
      push_item.offset    = bitpos[OFF_W-1:0];
      push_item.width     = w_eff;
      push_item.word      = bitpos[OFF_W+WIDX_W-1:OFF_W];
      push_item.value     = req_chan.value & width_mask(w_eff);
   end

   // accept while the store is ready and the queue has room
   assign req_chan.ready = !clearing && !q_status.full;
   assign push           = req_chan.valid && req_chan.ready;

endmodule
`default_nettype wire

// File: rtl/pbaa_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module pbaa_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire pbaa_pkg::work_item_type    push_item,
   input  wire logic                       pop,
   output pbaa_pkg::work_item_type         head_item,
   output pbaa_pkg::queue_status_type      q_status
);
   import pbaa_pkg::*;

   work_item_type entry_ff [2];
   logic          wr_ptr_ff;
   logic          wr_ptr_in;
   logic          rd_ptr_ff;
   logic          rd_ptr_in;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store pushed items
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = entry_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == 2'd2;
   assign q_status.empty = count_ff == 2'd0;

endmodule
`default_nettype wire

// File: rtl/pbaa_back.sv
// Back end: clearing pass, banked word store, load and OR-store execution.
`default_nettype none
`include "assert_macros.svh"
module pbaa_back #(
   parameter int STORE_WORDS = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pbaa_pkg::work_item_type    head_item,
   input  wire pbaa_pkg::queue_status_type q_status,
   output logic                            pop,
   output logic                            clearing,
   pbaa_rsp_if.source                      rsp_chan
);
   import pbaa_pkg::*;

   localparam int BANK_DEPTH = (STORE_WORDS + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam logic [BANK_AW-1:0] LAST_ADDR = BANK_AW'(BANK_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EXEC = 3'b100
   } back_state_type;

   back_state_type      state_ff;
   back_state_type      state_in;
   logic                clearing_ff;
   logic                clearing_in;
   logic [BANK_AW-1:0]  clr_addr_ff;
   logic [BANK_AW-1:0]  clr_addr_in;
   work_item_type       work_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [WORD_W-1:0]   rsp_value_ff;
   logic [WORD_W-1:0]   rsp_value_in;
   logic                rsp_oor_ff;
   logic                rsp_oor_in;

   logic [BANK_AW-1:0]  half_addr;
   logic [BANK_AW-1:0]  even_addr;
   logic                lo_odd;
   logic [WORD_W-1:0]   even_q;
   logic [WORD_W-1:0]   odd_q;
   logic [WORD_W-1:0]   lo_word;
   logic [WORD_W-1:0]   hi_word;
   logic [EBITS_W-1:0]  room;
   logic [WORD_W-1:0]   hi_part;
   logic [WORD_W-1:0]   load_value;
   logic [WORD_W-1:0]   st_lo;
   logic [WORD_W-1:0]   st_hi;
   logic                exec_store;
   logic                even_we;
   logic [BANK_AW-1:0]  even_waddr;
   logic [WORD_W-1:0]   even_wdata;
   logic                odd_we;
   logic [BANK_AW-1:0]  odd_waddr;
   logic [WORD_W-1:0]   odd_wdata;

   // sweep both banks to zero after reset
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + BANK_AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign clearing = clearing_ff;

   // take an item only when the response register will be free
   assign pop = (state_ff == ST_IDLE) && !clearing_ff && !q_status.empty
                && (!rsp_valid_ff || rsp_chan.ready);

   // sequence each item through read and execute
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the item being worked on
   always_ff @(posedge clock) begin
      if (pop) begin
         work_ff <= head_item;
      end
   end

   // map the first word and its successor onto even and odd banks
   assign lo_odd    = work_ff.word[0];
   assign half_addr = BANK_AW'(work_ff.word[WIDX_W-1:1]);
   assign even_addr = lo_odd ? half_addr + BANK_AW'(1) : half_addr;

   pbaa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_waddr),
      .wr_data (even_wdata),
      .rd_addr (even_addr),
      .rd_data (even_q)
   );

   pbaa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_waddr),
      .wr_data (odd_wdata),
      .rd_addr (half_addr),
      .rd_data (odd_q)
   );

   // extract the element and build the OR-updated words
   always_comb begin
      lo_word    = lo_odd ? odd_q : even_q;
      hi_word    = lo_odd ? even_q : odd_q;
      room       = 7'd64 - EBITS_W'(work_ff.offset);
      hi_part    = work_ff.spans ? (hi_word << room) : '0;
      load_value = ((lo_word >> work_ff.offset) | hi_part) & width_mask(work_ff.width);
      st_lo      = lo_word | (work_ff.value << work_ff.offset);
      st_hi      = hi_word | (work_ff.value >> room);
   end

   // write back the touched words, or zero during the sweep
   assign exec_store = (state_ff == ST_EXEC) && !work_ff.err
                       && (work_ff.operation == OP_STORE);

   always_comb begin
      if (clearing_ff) begin
         even_we    = 1'b1;
         even_waddr = clr_addr_ff;
         even_wdata = '0;
         odd_we     = 1'b1;
         odd_waddr  = clr_addr_ff;
         odd_wdata  = '0;
      end else begin
         even_we    = exec_store && (!lo_odd || work_ff.spans);
         even_waddr = even_addr;
         even_wdata = lo_odd ? st_hi : st_lo;
         odd_we     = exec_store && (lo_odd || work_ff.spans);
         odd_waddr  = half_addr;
         odd_wdata  = lo_odd ? st_lo : st_hi;
      end
   end

   // load and drop the response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_EXEC) begin
         rsp_valid_in = 1'b1;
         rsp_oor_in   = work_ff.err;
         rsp_value_in = (!work_ff.err && (work_ff.operation == OP_LOAD)) ? load_value : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_value   = rsp_value_ff;
   assign rsp_chan.out_of_range = rsp_oor_ff;

   `ASSERT_IMPLIES(a_oor_reads_zero, clock, reset, rsp_valid_ff && rsp_oor_ff, rsp_value_ff == '0)
   `ASSERT_IMPLIES(a_no_write_idle, clock, reset, (state_ff != ST_EXEC) && !clearing_ff, !even_we && !odd_we)
   `ASSERT_NEXT(a_exec_returns_idle, clock, reset, state_ff == ST_EXEC, state_ff == ST_IDLE)
   `ASSERT_IMPLIES(a_clear_quiet, clock, reset, clearing_ff, !rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
`default_nettype wire

// File: rtl/packed_bitfield_array_access_core.sv
// Top level of the packed integer array access core.
//
// A store of STORE_WORDS 64-bit words holds unsigned elements packed back to
// back at a width set by the csr port (csr_write_data, written when
// csr_write_enable is high; 0 acts as 1, above 64 acts as 64).
// Request items on req_chan carry an operation (load or OR-store), an element
// position and a value; each yields exactly one response item on rsp_chan
// with the loaded element and an out-of-range flag.
// A request is classified on acceptance and queued (two entries); the back end
// takes one item at a time through a bank read and an execute step, the
// read-modify-write of the even/odd word banks.
// After reset the banks are swept to zero, during which req_chan.ready stays
// low; csr writes are taken as usual.
// A stalled response holds in its output register; up to two more requests
// are accepted into the queue meanwhile, then req_chan.ready drops.
`default_nettype none
module packed_bitfield_array_access_core #(
   parameter int STORE_WORDS = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [pbaa_pkg::EBITS_W-1:0]  csr_write_data,
   pbaa_req_if.sink                           req_chan,
   pbaa_rsp_if.source                         rsp_chan
);
   import pbaa_pkg::*;

   logic             clearing;
   logic             push;
   logic             pop;
   work_item_type    push_item;
   work_item_type    head_item;
   queue_status_type q_status;

   pbaa_front #(
      .STORE_WORDS (STORE_WORDS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .clearing         (clearing),
      .q_status         (q_status),
      .push             (push),
      .push_item        (push_item)
   );

   pbaa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   pbaa_back #(
      .STORE_WORDS (STORE_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .q_status  (q_status),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the packed integer array access core.
`timescale 1ns / 1ps
module testbench;
   import pbaa_pkg::*;

   localparam int    STORE_WORDS = 4096;
   localparam int    STORE_BITS  = STORE_WORDS * WORD_W;
   localparam int    PHASES      = 8;
   localparam int    PHASE_ITEMS = 50;
   localparam longint TIMEOUT_NS = 5_000_000;
   localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_value;
      logic              out_of_range;
   } element_result_type;

   typedef struct packed {
      logic [EBITS_W-1:0] element_bits;
      logic               operation;
      logic [POS_W-1:0]   position;
      logic [WORD_W-1:0]  data_word;
      logic               typed;
      logic [WORD_W-1:0]  read_value;
      logic               out_of_range;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [EBITS_W-1:0] csr_write_data;

   pbaa_req_if req_chan ();
   pbaa_rsp_if rsp_chan ();

   packed_bitfield_array_access_core #(
      .STORE_WORDS(STORE_WORDS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // predictor state: shadow of the word store and of the width register
   logic [WORD_W-1:0]   packed_image [STORE_WORDS];
   logic [EBITS_W-1:0]  element_bits_reg;
   element_result_type  pending_results [$];
   element_result_type  oldest_result;
   int                  mismatch_count;
   int unsigned         sender_idle_pct;
   int unsigned         receiver_stall_pct;

   // directed items: width, operation, position, value, typed flag, result
   directed_row_type directed_rows [25] = '{
      '{7'd1,   OP_LOAD,  18'd0,      64'd0, 1'b1, 64'd0, 1'b0},
      '{7'd1,   OP_LOAD,  18'd262143, 64'd0, 1'b1, 64'd0, 1'b0},
      '{7'd1,   OP_STORE, 18'd5,      ONES,  1'b1, 64'd0, 1'b0},
      '{7'd1,   OP_LOAD,  18'd5,      64'd0, 1'b1, 64'd1, 1'b0},
      '{7'd64,  OP_STORE, 18'd4095,   ONES,  1'b1, 64'd0, 1'b0},
      '{7'd64,  OP_LOAD,  18'd4095,   64'd0, 1'b1, ONES,  1'b0},
      '{7'd64,  OP_LOAD,  18'd4096,   64'd0, 1'b1, 64'd0, 1'b1},
      '{7'd64,  OP_STORE, 18'd262143, ONES,  1'b1, 64'd0, 1'b1},
      '{7'd64,  OP_STORE, 18'd7, 64'hA5A5_5A5A_F00F_0FF0, 1'b1, 64'd0, 1'b0},
      '{7'd64,  OP_LOAD,  18'd7,      64'd0, 1'b0, 64'd0, 1'b0},
      '{7'd0,   OP_LOAD,  18'd262143, 64'd0, 1'b0, 64'd0, 1'b0},
      '{7'd0,   OP_STORE, 18'd64,     64'd3, 1'b1, 64'd0, 1'b0},
      '{7'd0,   OP_LOAD,  18'd64,     64'd0, 1'b0, 64'd0, 1'b0},
      '{7'd127, OP_LOAD,  18'd4095,   64'd0, 1'b0, 64'd0, 1'b0},
      '{7'd127, OP_LOAD,  18'd4096,   64'd0, 1'b1, 64'd0, 1'b1},
      '{7'd13,  OP_STORE, 18'd4,  64'hFFFF, 1'b1, 64'd0, 1'b0},
      '{7'd13,  OP_LOAD,  18'd4,      64'd0, 1'b0, 64'd0, 1'b0},
      '{7'd13,  OP_LOAD,  18'd3,      64'd0, 1'b0, 64'd0, 1'b0},
      '{7'd13,  OP_LOAD,  18'd5,      64'd0, 1'b0, 64'd0, 1'b0},
      '{7'd63,  OP_LOAD,  18'd4161,   64'd0, 1'b1, 64'd0, 1'b1},
      '{7'd63,  OP_STORE, 18'd4160,   ONES,  1'b1, 64'd0, 1'b0},
      '{7'd63,  OP_LOAD,  18'd4160,   64'd0, 1'b0, 64'd0, 1'b0},
      '{7'd63,  OP_STORE, 18'd1,      ONES,  1'b1, 64'd0, 1'b0},
      '{7'd63,  OP_LOAD,  18'd1,      64'd0, 1'b0, 64'd0, 1'b0},
      '{7'd63,  OP_LOAD,  18'd0,      64'd0, 1'b0, 64'd0, 1'b0}
   };

   // clock: 20 ns period
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // width in force: zero acts as one, above 64 saturates
   function automatic int unsigned active_width();
      if (element_bits_reg == '0) return 1;
      if (element_bits_reg > 7'd64) return 64;
      return 32'(element_bits_reg);
   endfunction

   // compute the result of one access and apply a store to the shadow image
   function automatic element_result_type access_element(input logic op,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic [WORD_W-1:0] data_word);
      int unsigned        width;
      int unsigned        bit_index;
      int unsigned        word_index;
      int unsigned        offset;
      int unsigned        room;
      logic [WORD_W-1:0]  mask;
      logic [WORD_W-1:0]  field;
      element_result_type result;
      width      = active_width();
      mask       = (width == 64) ? ONES : ((64'd1 << width) - 64'd1);
      bit_index  = pos * width;
      word_index = bit_index / WORD_W;
      offset     = bit_index % WORD_W;
      room       = WORD_W - offset;
      result     = '0;
      // drop elements that run past the end of the store
      if (bit_index + width > STORE_BITS) begin
         result.out_of_range = 1'b1;
         return result;
      end
      if (op == OP_LOAD) begin
         field = packed_image[word_index] >> offset;
         if (room < width) field |= packed_image[word_index + 1] << room;
         result.read_value = field & mask;
      end else begin
         field = data_word & mask;
         packed_image[word_index] |= field << offset;
         if (room < width) packed_image[word_index + 1] |= field >> room;
      end
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("%0t ns mismatch: %s", $time, what);
   endtask

   // hand one item to the block; starts and returns at a falling edge
   task automatic issue_access(input logic op, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] data_word, input logic typed,
                               input element_result_type typed_result);
      element_result_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.position  <= pos;
      req_chan.value     <= data_word;
      do @(posedge clock); while (!req_chan.ready);
      predicted = access_element(op, pos, data_word);
      pending_results.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   // hold until every result is back, then let the pipeline settle
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_element_bits(input logic [EBITS_W-1:0] bits);
      csr_write_enable <= 1'b1;
      csr_write_data   <= bits;
      @(posedge clock);
      element_bits_reg = bits;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      case (mode)
         IDLE_SENDER: begin
            sender_idle_pct = 81;
         end
         IDLE_RECEIVER: begin
            receiver_stall_pct = 81;
         end
         IDLE_BOTH: begin
            sender_idle_pct    = 24;
            receiver_stall_pct = 24;
         end
         default: begin
         end
      endcase
   endtask

   // receiver: stall at random, change at the falling edge
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_chan.read_value !== oldest_result.read_value)
               report_mismatch($sformatf("read_value %h, expected %h",
                                         rsp_chan.read_value, oldest_result.read_value));
            if (rsp_chan.out_of_range !== oldest_result.out_of_range)
               report_mismatch($sformatf("out_of_range %b, expected %b",
                                         rsp_chan.out_of_range,
                                         oldest_result.out_of_range));
         end
      end
   end

   // stimulus
   initial begin
      int unsigned        width;
      int unsigned        last_pos;
      int unsigned        hot_base;
      int unsigned        pick;
      logic               op;
      logic [POS_W-1:0]   pos;
      logic [WORD_W-1:0]  data_word;
      element_result_type typed_result;
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_chan.valid     = 1'b0;
      req_chan.operation = OP_LOAD;
      req_chan.position  = '0;
      req_chan.value     = '0;
      mismatch_count     = 0;
      element_bits_reg   = 7'd1;
      set_idle_mode(IDLE_NONE);
      foreach (packed_image[i]) packed_image[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items; change the width only once the block is idle
      foreach (directed_rows[i]) begin
         if (directed_rows[i].element_bits != element_bits_reg) begin
            wait_drained();
            write_element_bits(directed_rows[i].element_bits);
         end
         typed_result.read_value   = directed_rows[i].read_value;
         typed_result.out_of_range = directed_rows[i].out_of_range;
         issue_access(directed_rows[i].operation, directed_rows[i].position,
                      directed_rows[i].data_word, directed_rows[i].typed, typed_result);
      end

      // random phases, each with its own width and idle pattern
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: write_element_bits(7'd64);
            1: write_element_bits(7'd1);
            2: write_element_bits(7'd0);
            3: write_element_bits(7'd127);
            default: write_element_bits(7'($urandom_range(2, 63)));
         endcase
         set_idle_mode(idle_mode_type'(phase % 4));
         width    = active_width();
         last_pos = STORE_BITS / width - 1;
         hot_base = $urandom_range(0, last_pos - 31);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // pause once until every result is back
            if (phase == 5 && n == 20) begin
               req_chan.valid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
               @(negedge clock);
            end
            op   = $urandom_range(0, 1) ? OP_STORE : OP_LOAD;
            pick = $urandom_range(0, 99);
            if (pick < 50)
               pos = POS_W'(hot_base + $urandom_range(0, 31));
            else if (pick < 70)
               pos = POS_W'(last_pos - 2 + $urandom_range(0, 4));
            else
               pos = POS_W'($urandom);
            data_word = {$urandom, $urandom};
            // keep about half of the stored values sparse so loads still see new bits
            if ($urandom_range(0, 1))
               data_word &= {$urandom, $urandom} & {$urandom, $urandom};
            issue_access(op, pos, data_word, 1'b0, '0);
         end
      end

      // drain and settle
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
